// ===== design/pvec_pkg.sv =====
// Shared types and constants for the packed two-bit symbol vector.
`default_nettype none

package pvec_pkg;

	localparam int WORD_BITS = 64;
	localparam int SYMS_PER_WORD = 32;
	localparam int MAX_USED_WORDS = 32;
	localparam logic [10:0] LEN_LIMIT = 11'd1024;

	localparam logic [2:0] FUNC_INSERT = 3'd0;
	localparam logic [2:0] FUNC_REMOVE = 3'd1;
	localparam logic [2:0] FUNC_READ   = 3'd2;
	localparam logic [2:0] FUNC_CLEAR  = 3'd3;
	localparam logic [2:0] FUNC_HASH   = 3'd4;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_BAD  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_REM,
		CELL_CLR
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [4:0] widx;
		logic [4:0] seg;
		logic [1:0] sym;
	} cell_cmd_t;

	// mask over the lowest n symbols of a word
	function automatic logic [63:0] low_mask(input logic [5:0] n);
		logic [63:0] m;
		m = '1;
		if (n < 6'd32) begin
			m = (64'd1 << {n, 1'b0}) - 64'd1;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/pvec_cell.sv =====
// One word cell of the symbol chain: holds 32 packed symbols and shifts with its neighbors.
`default_nettype none

module pvec_cell #(
	parameter int CELL_IDX = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pvec_pkg::cell_cmd_t  cmd,
	input  wire  [1:0]           prev_top,
	input  wire  [1:0]           next_low,
	output logic [63:0]          word
);
	import pvec_pkg::*;

	localparam logic [4:0] IDX = 5'(CELL_IDX);

	logic [63:0] word_q;
	logic [63:0] keep;
	logic [63:0] keep1;
	logic [63:0] ins_word;
	logic [63:0] rem_word;
	logic [63:0] shl_word;
	logic [63:0] shr_word;
	logic        at_w;
	logic        above_w;

	always_comb begin
		keep     = low_mask({1'b0, cmd.seg});
		keep1    = low_mask({1'b0, cmd.seg} + 6'd1);
		ins_word = (word_q & keep) | ((word_q & ~keep) << 2)
		         | ({62'd0, cmd.sym} << {cmd.seg, 1'b0});
		rem_word = (word_q & keep) | ((word_q & ~keep1) >> 2) | {next_low, 62'd0};
		shl_word = {word_q[61:0], prev_top};
		shr_word = {next_low, word_q[63:2]};
		at_w     = (cmd.widx == IDX);
		above_w  = (cmd.widx < IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			case (cmd.op)
				CELL_INS: begin
					if (at_w) word_q <= ins_word;
					else if (above_w) word_q <= shl_word;
				end
				CELL_REM: begin
					if (at_w) word_q <= rem_word;
					else if (above_w) word_q <= shr_word;
				end
				CELL_CLR: word_q <= '0;
				default: ;
			endcase
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

// ===== design/packed_two_bit_symbol_vector.sv =====
// Top level: command decode, chain of word cells, read/hash port and output register.
// Insert, remove, read and clear: result registered in the cycle after the word is accepted;
// one word per cycle sustained while no hash runs and the result port is not stalled.
// Hash: sweeps one stored word per cycle through the read port, min(WORD_COUNT, 32) words in all,
// and folds the last word into the result once it is free; no new word is taken during the sweep.
// Reset (arst_n low) clears all words and the length at once; no clearing pass.
`default_nettype none

module packed_two_bit_symbol_vector #(
	parameter int WORD_COUNT = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // position[9:0], symbol_in[11:10], zero pad
	input  wire  [2:0]  s_tuser,   // func[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [79:0] m_tdata    // status[1:0], symbol_out[3:2], length_out[14:4],
	                               // digest[78:15], zero pad
);
	import pvec_pkg::*;

	localparam int USED_WORDS = (WORD_COUNT < MAX_USED_WORDS) ? WORD_COUNT : MAX_USED_WORDS;
	localparam int UIDX = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
	localparam int CAP = (WORD_COUNT * SYMS_PER_WORD < 1024) ? WORD_COUNT * SYMS_PER_WORD : 1024;
	localparam logic [10:0] LEN_CAP = 11'(CAP);
	localparam logic [UIDX-1:0] LAST_IDX = UIDX'(USED_WORDS - 1);

	typedef enum logic {ST_IDLE, ST_HASH} state_t;

	state_t          state_q;
	logic [10:0]     count_q;
	logic [63:0]     acc_q;
	logic [UIDX-1:0] hidx_q;
	logic            m_tvalid_q;
	logic [79:0]     m_tdata_q;

	logic [63:0]     words [USED_WORDS];
	cell_cmd_t       cmd;
	logic [2:0]      func;
	logic [9:0]      pos;
	logic [1:0]      sym;
	logic [10:0]     pos_ext;
	logic            accept;
	logic            out_free;
	logic            res_load;
	logic [UIDX-1:0] ridx;
	logic [UIDX-1:0] addr;
	logic [63:0]     rd_word;
	logic [1:0]      rd_sym;
	logic [1:0]      res_status;
	logic [1:0]      res_sym;
	logic [10:0]     cnt_next;
	cell_op_t        op_next;

	assign func    = s_tuser;
	assign pos     = s_tdata[9:0];
	assign sym     = s_tdata[11:10];
	assign pos_ext = {1'b0, pos};

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign res_load = (accept && (func != FUNC_HASH))
	               || ((state_q == ST_HASH) && (hidx_q == LAST_IDX) && out_free);

	generate
		if (USED_WORDS > 1) begin : g_ridx
			assign ridx = pos[5 +: UIDX];
		end else begin : g_ridx1
			assign ridx = 1'b0;
		end
	endgenerate

	// one read port, shared by the read command and the hash sweep
	assign addr    = (state_q == ST_HASH) ? hidx_q : ridx;
	assign rd_word = words[addr];
	assign rd_sym  = 2'(rd_word >> {pos[4:0], 1'b0});

	always_comb begin
		res_status = STATUS_OK;
		res_sym    = 2'd0;
		cnt_next   = count_q;
		op_next    = CELL_HOLD;
		case (func)
			FUNC_INSERT: begin
				if (pos_ext > count_q) begin
					res_status = STATUS_BAD;
				end else if (count_q >= LEN_CAP) begin
					res_status = STATUS_FULL;
				end else begin
					cnt_next = count_q + 11'd1;
					op_next  = CELL_INS;
				end
			end
			FUNC_REMOVE: begin
				if (pos_ext >= count_q) begin
					res_status = STATUS_BAD;
				end else begin
					cnt_next = count_q - 11'd1;
					op_next  = CELL_REM;
				end
			end
			FUNC_READ: begin
				if (pos_ext >= count_q) res_status = STATUS_BAD;
				else res_sym = rd_sym;
			end
			FUNC_CLEAR: begin
				cnt_next = 11'd0;
				op_next  = CELL_CLR;
			end
			default: ;
		endcase
		cmd.op   = accept ? op_next : CELL_HOLD;
		cmd.widx = pos[9:5];
		cmd.seg  = pos[4:0];
		cmd.sym  = sym;
	end

	generate
		for (genvar i = 0; i < USED_WORDS; i++) begin : g_cell
			logic [1:0] prev_top;
			logic [1:0] next_low;
			if (i == 0) begin : g_first
				assign prev_top = 2'd0;
			end else begin : g_mid
				assign prev_top = words[i-1][63:62];
			end
			if (i == USED_WORDS - 1) begin : g_last
				assign next_low = 2'd0;
			end else begin : g_inner
				assign next_low = words[i+1][1:0];
			end
			pvec_cell #(
				.CELL_IDX(i)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd),
				.prev_top(prev_top),
				.next_low(next_low),
				.word    (words[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			acc_q      <= '0;
			hidx_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_next;
						if (func == FUNC_HASH) begin
							state_q <= ST_HASH;
							acc_q   <= {53'd0, count_q};
							hidx_q  <= '0;
						end else begin
							m_tdata_q <= {1'b0, 64'd0, cnt_next, res_sym, res_status};
						end
					end
				end
				ST_HASH: begin
					if (hidx_q != LAST_IDX) begin
						acc_q  <= acc_q ^ rd_word;
						hidx_q <= hidx_q + UIDX'(1);
					end else if (out_free) begin
						// fold the last word straight into the result
						m_tdata_q <= {1'b0, acc_q ^ rd_word, count_q, 2'd0, STATUS_OK};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== design/pvec_checker.sv =====
// Port-level checks for the packed two-bit symbol vector, bound to the top level.
`default_nettype none

module pvec_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [79:0] m_tdata
);
	import pvec_pkg::*;

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed or dropped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("status code out of range");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:4] <= LEN_LIMIT)
		else $error("length above limit");

	a_err_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != STATUS_OK |-> m_tdata[3:2] == 2'd0)
		else $error("symbol nonzero on error result");

	// the length moves by at most one between consecutive results unless cleared
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready ##1 m_tvalid && m_tdata[14:4] != 11'd0
		|-> m_tdata[14:4] == $past(m_tdata[14:4])
		 || m_tdata[14:4] == $past(m_tdata[14:4]) + 11'd1
		 || m_tdata[14:4] + 11'd1 == $past(m_tdata[14:4]))
		else $error("length jumped between results");

endmodule

bind packed_two_bit_symbol_vector pvec_checker u_pvec_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
